### rtl/pfc_pkg.sv
// Shared types, constants and helper functions for the Playfair digraph cipher.
// Depends on nothing; RTL files use scoped names into it, the bench imports it.
`timescale 1ns / 1ps

package pfc_pkg;

  localparam int SQUARE_SIDE = 5;
  localparam int CELL_COUNT  = SQUARE_SIDE * SQUARE_SIDE;
  localparam int LETTER_W    = 5;
  localparam int POS_W       = 3;
  localparam int IDX_W       = 5;

  localparam logic [LETTER_W-1:0] FILLER_X = 5'd23;

  localparam int CFG_DATA_W = 60;
  localparam int CFG_IDX_W  = 2;
  localparam int FINAL_W    = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SQ_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SQ_MIDDLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQ_FINAL  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef logic [CELL_COUNT-1:0][LETTER_W-1:0] square_t;

  // One digraph on its way from the front to the back.
  typedef struct packed {
    logic [LETTER_W-1:0] a;
    logic [LETTER_W-1:0] b;
    logic                last;
    logic                done;
  } pair_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } loc_t;

  // First matching cell in row-major order wins, so the scan runs from the end.
  function automatic loc_t locate_f(square_t sq, logic [LETTER_W-1:0] v);
    loc_t loc;
    loc = '0;
    for (int k = CELL_COUNT - 1; k >= 0; k--) begin
      if (sq[k] == v) begin
        loc.found = 1'b1;
        loc.row   = POS_W'(k / SQUARE_SIDE);
        loc.col   = POS_W'(k % SQUARE_SIDE);
      end
    end
    return loc;
  endfunction

  function automatic logic [POS_W-1:0] step_f(logic [POS_W-1:0] pos, logic decrypt);
    logic [POS_W-1:0] res;
    if (decrypt) begin
      res = (pos == POS_W'(0)) ? POS_W'(SQUARE_SIDE - 1) : pos - POS_W'(1);
    end else begin
      res = (pos == POS_W'(SQUARE_SIDE - 1)) ? POS_W'(0) : pos + POS_W'(1);
    end
    return res;
  endfunction

  function automatic logic [LETTER_W-1:0] cell_f(square_t sq, logic [POS_W-1:0] row,
                                                 logic [POS_W-1:0] col);
    logic [IDX_W-1:0] idx;
    idx = IDX_W'(row) * IDX_W'(SQUARE_SIDE) + IDX_W'(col);
    return sq[idx];
  endfunction

endpackage

### rtl/pfc_front.sv
// Front end: accepts letters, keeps the pending letter and forms digraphs.
// Uses pfc_pkg; feeds pairs into pfc_queue.
`timescale 1ns / 1ps

module pfc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pfc_pkg::LETTER_W-1:0]  letter_i,
  input  logic                          end_of_text_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output pfc_pkg::pair_t                push_data_o
);

  logic [pfc_pkg::LETTER_W-1:0] held_q, held_d;
  logic                         held_valid_q, held_valid_d;
  logic [pfc_pkg::LETTER_W-1:0] extra_q, extra_d;
  logic                         extra_valid_q, extra_valid_d;
  logic                         accept;

  // A repeat on the last letter makes two pairs; the second waits in the extra slot.
  assign in_ready_o = !extra_valid_q && push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    held_d        = held_q;
    held_valid_d  = held_valid_q;
    extra_d       = extra_q;
    extra_valid_d = extra_valid_q;
    push_valid_o  = 1'b0;
    push_data_o   = '0;

    if (extra_valid_q) begin
      push_valid_o     = 1'b1;
      push_data_o.a    = extra_q;
      push_data_o.b    = pfc_pkg::FILLER_X;
      push_data_o.last = 1'b1;
      push_data_o.done = 1'b1;
      if (push_ready_i) begin
        extra_valid_d = 1'b0;
      end
    end else if (accept) begin
      if (!held_valid_q) begin
        if (end_of_text_i) begin
          push_valid_o     = 1'b1;
          push_data_o.a    = letter_i;
          push_data_o.b    = pfc_pkg::FILLER_X;
          push_data_o.last = 1'b1;
          push_data_o.done = 1'b1;
        end else begin
          held_d       = letter_i;
          held_valid_d = 1'b1;
        end
      end else if (letter_i == held_q) begin
        push_valid_o     = 1'b1;
        push_data_o.a    = held_q;
        push_data_o.b    = pfc_pkg::FILLER_X;
        push_data_o.last = !end_of_text_i;
        push_data_o.done = 1'b0;
        if (end_of_text_i) begin
          extra_d       = letter_i;
          extra_valid_d = 1'b1;
        end
      end else begin
        push_valid_o     = 1'b1;
        push_data_o.a    = held_q;
        push_data_o.b    = letter_i;
        push_data_o.last = 1'b1;
        push_data_o.done = end_of_text_i;
        held_valid_d     = 1'b0;
      end
      if (end_of_text_i) begin
        held_valid_d = 1'b0;
        held_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q        <= '0;
      held_valid_q  <= 1'b0;
      extra_valid_q <= 1'b0;
    end else begin
      held_q        <= held_d;
      held_valid_q  <= held_valid_d;
      extra_valid_q <= extra_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    extra_q <= extra_d;
  end

endmodule

### rtl/pfc_queue.sv
// Short pair queue between the front end and the cipher back end.
// Uses pfc_pkg for the pair type and the depth.
`timescale 1ns / 1ps

module pfc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  pfc_pkg::pair_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output pfc_pkg::pair_t pop_data_o
);

  pfc_pkg::pair_t               mem_q [pfc_pkg::QUEUE_DEPTH];
  logic [pfc_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [pfc_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [pfc_pkg::QCNT_W-1:0]   count_q, count_d;
  logic                         do_push, do_pop;

  assign push_ready_o = (count_q != pfc_pkg::QCNT_W'(pfc_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == pfc_pkg::QPTR_W'(pfc_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + pfc_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == pfc_pkg::QPTR_W'(pfc_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + pfc_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + pfc_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - pfc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/pfc_back.sv
// Back end: locates each digraph in the key square, applies the cipher rule
// and sends the two letters out one per cycle while out_ready_i holds. Uses pfc_pkg.
`timescale 1ns / 1ps

module pfc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfc_pkg::square_t              square_i,
  input  logic                          decrypt_i,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  pfc_pkg::pair_t                pop_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pfc_pkg::LETTER_W-1:0]  out_letter_o,
  output logic                          run_last_o,
  output logic                          text_done_o,
  output logic                          not_found_o
);

  // Locate stage.
  logic           loc_valid_q;
  pfc_pkg::pair_t loc_pair_q;
  pfc_pkg::loc_t  loc_a_q, loc_b_q;
  logic           loc_ready;

  // Output stage, holding both result letters of a pair.
  logic                         res_valid_q;
  logic                         res_sel_q;
  logic [pfc_pkg::LETTER_W-1:0] res_a_q, res_b_q, res_a_d, res_b_d;
  logic                         res_nf_q, res_nf_d;
  logic                         res_last_q, res_done_q;
  logic                         res_take;

  assign res_take    = !res_valid_q || (out_ready_i && res_sel_q);
  assign loc_ready   = !loc_valid_q || res_take;
  assign pop_ready_o = loc_ready;

  always_comb begin
    res_a_d  = loc_pair_q.a;
    res_b_d  = loc_pair_q.b;
    res_nf_d = 1'b1;
    if (loc_a_q.found && loc_b_q.found) begin
      res_nf_d = 1'b0;
      if (loc_a_q.row == loc_b_q.row) begin
        res_a_d = pfc_pkg::cell_f(square_i, loc_a_q.row,
                                  pfc_pkg::step_f(loc_a_q.col, decrypt_i));
        res_b_d = pfc_pkg::cell_f(square_i, loc_b_q.row,
                                  pfc_pkg::step_f(loc_b_q.col, decrypt_i));
      end else if (loc_a_q.col == loc_b_q.col) begin
        res_a_d = pfc_pkg::cell_f(square_i, pfc_pkg::step_f(loc_a_q.row, decrypt_i),
                                  loc_a_q.col);
        res_b_d = pfc_pkg::cell_f(square_i, pfc_pkg::step_f(loc_b_q.row, decrypt_i),
                                  loc_b_q.col);
      end else begin
        res_a_d = pfc_pkg::cell_f(square_i, loc_a_q.row, loc_b_q.col);
        res_b_d = pfc_pkg::cell_f(square_i, loc_b_q.row, loc_a_q.col);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      res_sel_q   <= 1'b0;
    end else begin
      if (loc_ready) begin
        loc_valid_q <= pop_valid_i;
      end
      if (res_take) begin
        res_valid_q <= loc_valid_q;
        res_sel_q   <= 1'b0;
      end else if (out_ready_i) begin
        res_sel_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (loc_ready && pop_valid_i) begin
      loc_pair_q <= pop_data_i;
      loc_a_q    <= pfc_pkg::locate_f(square_i, pop_data_i.a);
      loc_b_q    <= pfc_pkg::locate_f(square_i, pop_data_i.b);
    end
    if (res_take && loc_valid_q) begin
      res_a_q    <= res_a_d;
      res_b_q    <= res_b_d;
      res_nf_q   <= res_nf_d;
      res_last_q <= loc_pair_q.last;
      res_done_q <= loc_pair_q.done;
    end
  end

  assign out_valid_o  = res_valid_q;
  assign out_letter_o = res_sel_q ? res_b_q : res_a_q;
  assign run_last_o   = res_sel_q && res_last_q;
  assign text_done_o  = res_sel_q && res_done_q;
  assign not_found_o  = res_nf_q;

endmodule

### rtl/playfair_digraph_cipher_top.sv
// Top level of the Playfair digraph cipher: key square and mode registers,
// front end, pair queue and back end. Uses pfc_pkg, pfc_front, pfc_queue, pfc_back.
`timescale 1ns / 1ps

// Letters (codes 0 to 31) enter one per transfer with an end-of-text flag. Every
// digraph leaves as two letters, first a then b, and the output port moves one
// letter per cycle while out_ready_i is high, so the output sets the sustained
// rate. Ordinary text, where two input letters form one pair, keeps pace with it.
// A repeated letter or a lone final letter is paired with an X filler and so
// makes a pair by itself. A new letter is taken every cycle while the two-entry
// pair queue has room and no second pair waits in the front end's extra slot.
// The first letter of a pair reaches the output through the pair queue, the
// locate stage and the output stage, which holds the substituted letters, each
// of them registered. A repeated letter at the end of a text makes two pairs
// and holds the input until the second pair has gone into the queue. The user
// must write the key square and the mode through the configuration port only
// while the block is idle; the block itself does not enforce this.
module playfair_digraph_cipher_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pfc_pkg::LETTER_W-1:0]    letter_i,
  input  logic                            end_of_text_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pfc_pkg::LETTER_W-1:0]    out_letter_o,
  output logic                            run_last_o,
  output logic                            text_done_o,
  output logic                            not_found_o
);

  logic [pfc_pkg::CFG_DATA_W-1:0] sq_first_q;
  logic [pfc_pkg::CFG_DATA_W-1:0] sq_middle_q;
  logic [pfc_pkg::FINAL_W-1:0]    sq_final_q;
  logic                           mode_q;
  pfc_pkg::square_t               square;

  logic           push_valid, push_ready;
  pfc_pkg::pair_t push_data;
  logic           pop_valid, pop_ready;
  pfc_pkg::pair_t pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_first_q  <= '0;
      sq_middle_q <= '0;
      sq_final_q  <= '0;
      mode_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pfc_pkg::CFG_SQ_FIRST:  sq_first_q  <= cfg_data_i;
        pfc_pkg::CFG_SQ_MIDDLE: sq_middle_q <= cfg_data_i;
        pfc_pkg::CFG_SQ_FINAL:  sq_final_q  <= cfg_data_i[pfc_pkg::FINAL_W-1:0];
        pfc_pkg::CFG_MODE:      mode_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Cell k sits at bits 5k+4..5k of the concatenation, in row-major order.
  assign square = {sq_final_q, sq_middle_q, sq_first_q};

  pfc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .letter_i      (letter_i),
    .end_of_text_i (end_of_text_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  pfc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  pfc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .square_i     (square),
    .decrypt_i    (mode_q),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_letter_o (out_letter_o),
    .run_last_o   (run_last_o),
    .text_done_o  (text_done_o),
    .not_found_o  (not_found_o)
  );

endmodule

### bench/playfair_digraph_cipher_top_test.sv
// Self-checking bench for playfair_digraph_cipher_top: directed digraph cases, then random
// texts over random key squares, with results checked against a Playfair predictor.
// Depends on pfc_pkg and the RTL of playfair_digraph_cipher_top.
`timescale 1ns / 1ps

module playfair_digraph_cipher_top_test;
  import pfc_pkg::*;

  localparam logic MODE_ENCRYPT   = 1'b0;
  localparam logic MODE_DECRYPT   = 1'b1;
  localparam int   ALPHABET       = 26;
  localparam int   IDLE_PCT       = 29;
  localparam int   SETTLE_CYCLES  = 8;
  localparam int   TAIL_CYCLES    = 16;
  localparam int   WATCHDOG_LIMIT = 1000;
  localparam int   SEGMENTS       = 5;
  localparam int   SEG_ITEMS      = 57;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                run_last;
    logic                text_done;
    logic                not_found;
  } cipher_out_t;

  // One line of the stimulus plan: either a register write or one text letter.
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic [LETTER_W-1:0]   letter;
    logic                  eot;
    logic                  typed;
    logic [2:0]            n_typed;
    cipher_out_t [3:0]     typed_out;
  } cipher_step_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic [LETTER_W-1:0]   letter_i      = '0;
  logic                  end_of_text_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [LETTER_W-1:0]   out_letter_o;
  logic                  run_last_o;
  logic                  text_done_o;
  logic                  not_found_o;

  // Predictor state: the key square, the mode and the pending letter.
  logic [LETTER_W-1:0] key_cell [CELL_COUNT];
  logic                decrypt_mode = 1'b0;
  logic [LETTER_W-1:0] pend_letter  = '0;
  logic                pend_valid   = 1'b0;

  cipher_out_t         pair_letters[$];
  cipher_out_t         pending_letters[$];
  cipher_step_t        step_plan[$];
  logic [LETTER_W-1:0] plan_cells [CELL_COUNT];

  logic stall_on     = 1'b1;
  logic cfg_open     = 1'b0;
  int   fail_count   = 0;
  int   quiet_cycles = 0;

  playfair_digraph_cipher_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .letter_i      (letter_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_letter_o  (out_letter_o),
    .run_last_o    (run_last_o),
    .text_done_o   (text_done_o),
    .not_found_o   (not_found_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int find_cell(logic [LETTER_W-1:0] v);
    for (int k = 0; k < CELL_COUNT; k++) begin
      if (key_cell[k] == v) return k;
    end
    return -1;
  endfunction

  function automatic void code_pair(logic [LETTER_W-1:0] a, logic [LETTER_W-1:0] b);
    int pa, pb, ra, ca, rb, cb, st;
    cipher_out_t oa, ob;
    pa = find_cell(a);
    pb = find_cell(b);
    st = decrypt_mode ? SQUARE_SIDE - 1 : 1;
    oa = '0;
    ob = '0;
    if (pa < 0 || pb < 0) begin
      oa.letter    = a;
      ob.letter    = b;
      oa.not_found = 1'b1;
      ob.not_found = 1'b1;
    end else begin
      ra = pa / SQUARE_SIDE;
      ca = pa % SQUARE_SIDE;
      rb = pb / SQUARE_SIDE;
      cb = pb % SQUARE_SIDE;
      if (ra == rb) begin
        oa.letter = key_cell[ra * SQUARE_SIDE + (ca + st) % SQUARE_SIDE];
        ob.letter = key_cell[rb * SQUARE_SIDE + (cb + st) % SQUARE_SIDE];
      end else if (ca == cb) begin
        oa.letter = key_cell[((ra + st) % SQUARE_SIDE) * SQUARE_SIDE + ca];
        ob.letter = key_cell[((rb + st) % SQUARE_SIDE) * SQUARE_SIDE + cb];
      end else begin
        oa.letter = key_cell[ra * SQUARE_SIDE + cb];
        ob.letter = key_cell[rb * SQUARE_SIDE + ca];
      end
    end
    pair_letters.push_back(oa);
    pair_letters.push_back(ob);
  endfunction

  // Digraph forming: a repeat of the pending letter pairs it with X and stays pending.
  function automatic void predict_cipher(logic [LETTER_W-1:0] l, logic e);
    cipher_out_t tail;
    pair_letters.delete();
    if (!pend_valid) begin
      if (e) begin
        code_pair(l, FILLER_X);
      end else begin
        pend_letter = l;
        pend_valid  = 1'b1;
      end
    end else if (l == pend_letter) begin
      code_pair(pend_letter, FILLER_X);
      if (e) code_pair(l, FILLER_X);
    end else begin
      code_pair(pend_letter, l);
      pend_valid = 1'b0;
    end
    if (e) begin
      pend_valid  = 1'b0;
      pend_letter = '0;
    end
    if (pair_letters.size() > 0) begin
      tail          = pair_letters[pair_letters.size() - 1];
      tail.run_last = 1'b1;
      if (e) tail.text_done = 1'b1;
      pair_letters[pair_letters.size() - 1] = tail;
    end
  endfunction

  function automatic void load_register(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_SQ_FIRST: begin
        for (int k = 0; k < 12; k++) key_cell[k] = data[5*k +: 5];
      end
      CFG_SQ_MIDDLE: begin
        for (int k = 0; k < 12; k++) key_cell[k + 12] = data[5*k +: 5];
      end
      CFG_SQ_FINAL: begin
        key_cell[CELL_COUNT - 1] = data[LETTER_W-1:0];
      end
      CFG_MODE: begin
        decrypt_mode = data[0];
      end
      default: ;
    endcase
  endfunction

  function automatic cipher_out_t cipher_result(logic [LETTER_W-1:0] l, logic rl, logic td,
                                                logic nf);
    cipher_out_t r;
    r.letter    = l;
    r.run_last  = rl;
    r.text_done = td;
    r.not_found = nf;
    return r;
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cipher_step_t r;
    r          = '0;
    r.is_cfg   = 1'b1;
    r.reg_idx  = idx;
    r.reg_data = data;
    step_plan.push_back(r);
  endfunction

  function automatic void add_letter(logic [LETTER_W-1:0] l, logic e);
    cipher_step_t r;
    r        = '0;
    r.letter = l;
    r.eot    = e;
    step_plan.push_back(r);
  endfunction

  function automatic void add_checked(logic [LETTER_W-1:0] l, logic e, int n,
                                      cipher_out_t r0, cipher_out_t r1,
                                      cipher_out_t r2, cipher_out_t r3);
    cipher_step_t r;
    r           = '0;
    r.letter    = l;
    r.eot       = e;
    r.typed     = 1'b1;
    r.n_typed   = 3'(n);
    r.typed_out = {r3, r2, r1, r0};
    step_plan.push_back(r);
  endfunction

  // Queues writes of plan_cells and the mode; unused upper bits of the narrow registers get noise.
  function automatic void plan_square(logic mode);
    logic [CFG_DATA_W-1:0] w0, w1, w2, w3;
    w2 = CFG_DATA_W'({$urandom, $urandom});
    w3 = CFG_DATA_W'({$urandom, $urandom});
    for (int k = 0; k < 12; k++) begin
      w0[5*k +: 5] = plan_cells[k];
      w1[5*k +: 5] = plan_cells[k + 12];
    end
    w2[LETTER_W-1:0] = plan_cells[CELL_COUNT - 1];
    w3[0]            = mode;
    add_reg(CFG_SQ_FIRST, w0);
    add_reg(CFG_SQ_MIDDLE, w1);
    add_reg(CFG_SQ_FINAL, w2);
    add_reg(CFG_MODE, w3);
  endfunction

  function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  // Register writes wait until the block has drained; letters go out as transfers.
  task automatic walk_plan();
    cipher_step_t r;
    while (step_plan.size() != 0) begin
      r = step_plan.pop_front();
      if (r.is_cfg) begin
        if (!cfg_open) begin
          in_valid_i <= 1'b0;
          while (pending_letters.size() != 0) @(posedge clk_i);
          repeat (SETTLE_CYCLES) @(posedge clk_i);
          cfg_open = 1'b1;
        end
        cfg_we_i    <= 1'b1;
        cfg_index_i <= r.reg_idx;
        cfg_data_i  <= r.reg_data;
        @(posedge clk_i);
        load_register(r.reg_idx, r.reg_data);
      end else begin
        if (cfg_open) begin
          cfg_we_i <= 1'b0;
          cfg_open = 1'b0;
        end
        if (stall_on && $urandom_range(99) < IDLE_PCT) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while ($urandom_range(99) < IDLE_PCT);
        end
        in_valid_i    <= 1'b1;
        letter_i      <= r.letter;
        end_of_text_i <= r.eot;
        do @(posedge clk_i); while (!in_ready_o);
        predict_cipher(r.letter, r.eot);
        if (r.typed) begin
          for (int i = 0; i < r.n_typed; i++) pending_letters.push_back(r.typed_out[i]);
        end else begin
          foreach (pair_letters[i]) pending_letters.push_back(pair_letters[i]);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= stall_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  always @(posedge clk_i) begin : result_check
    cipher_out_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_letters.size() == 0) begin
          $error("out_letter %0d arrived with no expectation waiting", out_letter_o);
          fail_count++;
        end else begin
          want = pending_letters.pop_front();
          check_field("out_letter", want.letter, out_letter_o);
          check_field("run_last", want.run_last, run_last_o);
          check_field("text_done", want.text_done, text_done_o);
          check_field("not_found", want.not_found, not_found_o);
        end
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int                  pick, j;
    logic [LETTER_W-1:0] l, prev, swap;
    logic                e;
    logic [LETTER_W-1:0] pool [ALPHABET];

    foreach (key_cell[k]) key_cell[k] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset square is all A, so only A is found and X never is.
    add_checked(5'd0, 1'b0, 0, '0, '0, '0, '0);
    add_checked(5'd0, 1'b1, 4, cipher_result(5'd0, 1'b0, 1'b0, 1'b1),
                cipher_result(FILLER_X, 1'b0, 1'b0, 1'b1),
                cipher_result(5'd0, 1'b0, 1'b0, 1'b1),
                cipher_result(FILLER_X, 1'b1, 1'b1, 1'b1));
    add_checked(5'd31, 1'b0, 0, '0, '0, '0, '0);
    add_checked(5'd2, 1'b1, 2, cipher_result(5'd31, 1'b0, 1'b0, 1'b1),
                cipher_result(5'd2, 1'b1, 1'b1, 1'b1), '0, '0);

    // Classic alphabet square without J.
    for (int k = 0; k < CELL_COUNT; k++) plan_cells[k] = LETTER_W'((k < 9) ? k : k + 1);
    plan_square(MODE_ENCRYPT);
    add_letter(5'd2, 1'b0);   // C over N: same column
    add_letter(5'd13, 1'b0);
    add_letter(5'd0, 1'b0);   // A and Z: rectangle corners
    add_letter(5'd25, 1'b0);
    add_letter(5'd4, 1'b0);   // E then A: row wraps around
    add_letter(5'd0, 1'b0);
    add_letter(5'd11, 1'b0);  // repeated L pairs with X, then L M closes the text
    add_letter(5'd11, 1'b0);
    add_letter(5'd12, 1'b1);
    add_letter(5'd26, 1'b0);  // unused code and the missing J
    add_letter(5'd9, 1'b1);
    add_letter(5'd25, 1'b1);  // lone final letter
    add_letter(5'd15, 1'b0);  // repeat on the last letter of a text
    add_letter(5'd15, 1'b1);
    add_letter(FILLER_X, 1'b0);  // X X sits in one cell
    add_letter(FILLER_X, 1'b0);
    add_letter(5'd1, 1'b1);
    plan_square(MODE_DECRYPT);
    add_letter(5'd0, 1'b0);
    add_letter(5'd1, 1'b1);

    // High codes in the square, with the corner duplicating the first cell.
    for (int k = 0; k < CELL_COUNT; k++) plan_cells[k] = LETTER_W'(31 - k);
    plan_cells[CELL_COUNT - 1] = 5'd31;
    plan_square(MODE_ENCRYPT);
    add_letter(5'd31, 1'b0);
    add_letter(5'd8, 1'b1);

    foreach (plan_cells[k]) plan_cells[k] = 5'd31;
    plan_square(MODE_DECRYPT);
    add_checked(5'd31, 1'b1, 2, cipher_result(5'd31, 1'b0, 1'b0, 1'b1),
                cipher_result(FILLER_X, 1'b1, 1'b1, 1'b1), '0, '0);
    walk_plan();

    for (int s = 0; s < SEGMENTS; s++) begin
      for (int k = 0; k < ALPHABET; k++) pool[k] = LETTER_W'(k);
      for (int k = ALPHABET - 1; k > 0; k--) begin
        j       = $urandom_range(k);
        swap    = pool[k];
        pool[k] = pool[j];
        pool[j] = swap;
      end
      // One segment uses arbitrary cells, so duplicates and high codes show up.
      for (int k = 0; k < CELL_COUNT; k++) begin
        plan_cells[k] = (s == 3) ? LETTER_W'($urandom_range(31)) : pool[k];
      end
      plan_square((s % 2 == 1) ? MODE_DECRYPT : MODE_ENCRYPT);
      prev = '0;
      for (int i = 0; i < SEG_ITEMS; i++) begin
        pick = $urandom_range(99);
        if (pick < 15 && i > 0) begin
          l = prev;
        end else if (pick < 25) begin
          l = LETTER_W'($urandom_range(31));
        end else begin
          l = plan_cells[$urandom_range(CELL_COUNT - 1)];
        end
        e = ($urandom_range(99) < 12) || (i == SEG_ITEMS - 1);
        add_letter(l, e);
        prev = l;
      end
      stall_on = (s != 1);
      walk_plan();
    end

    in_valid_i <= 1'b0;
    while (pending_letters.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/pfc_pkg.sv
rtl/pfc_front.sv
rtl/pfc_queue.sv
rtl/pfc_back.sv
rtl/playfair_digraph_cipher_top.sv
bench/playfair_digraph_cipher_top_test.sv
